>>> sv/ewv_pkg.sv
// Shared types, constants and helpers of the encoder window velocity unit.
package ewv_pkg;

   localparam int BYTE_W    = 8;
   localparam int TIME_W    = 32;
   localparam int CIRC_W    = 24;
   localparam int TRACK_W   = 16;
   localparam int SPEED_W   = 40;
   localparam int MICROS_W  = 20;
   localparam int TICK_SHIFT = 8;

   localparam logic [BYTE_W-1:0]   HDR_ENCODER = 8'hDD;
   localparam logic [BYTE_W-1:0]   CMD_LEFT    = 8'h60;
   localparam logic [BYTE_W-1:0]   CMD_RIGHT   = 8'h70;
   localparam logic [MICROS_W-1:0] MICROS_PER_SEC = 20'd1000000;

   localparam logic [CIRC_W-1:0]  CIRC_RESET  = 24'd25737;
   localparam logic [TRACK_W-1:0] TRACK_RESET = 16'd95;

   // divider sized for the widest speed dividend while the summing span is at most 64 entries
   localparam int DIV_W     = 50;
   localparam int DEN_W     = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [SPEED_W-1:0] sat_speed(input logic neg,
                                                    input logic [DIV_W-1:0] q);
      logic [DIV_W-1:0] lim;
      lim = DIV_W'(1) << (SPEED_W - 1);
      if (neg) begin
         if (q > lim) begin
            sat_speed = {1'b1, {(SPEED_W-1){1'b0}}};
         end else begin
            sat_speed = SPEED_W'(~q[SPEED_W-1:0] + SPEED_W'(1));
         end
      end else begin
         if (q > lim - DIV_W'(1)) begin
            sat_speed = {1'b0, {(SPEED_W-1){1'b1}}};
         end else begin
            sat_speed = q[SPEED_W-1:0];
         end
      end
   endfunction

endpackage

>>> sv/ewv_div.sv
// Shared restoring divider, one quotient bit per cycle.
module ewv_div
   import ewv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_W-1:0]     quo_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [DEN_W:0] rem_sh;
   logic [DEN_W:0] rem_sub;
   logic           fits;

   assign rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !div_req.start && busy_ff && (cnt_ff == DIV_CNT_W'(DIV_W - 1));
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= div_req.dividend;
            den_ff  <= div_req.divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            rem_ff <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> sv/encoder_window_velocity_unit.sv
// Top level of the windowed wheel encoder velocity estimator.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: header, command, tick, time
//  rsp     | out       | rsp_tvalid/tready    | tdata: speeds, rate; tuser: flags
//  csr     | in        | csr_wr_en            | csr_addr, csr_wdata
//
// Encoder frames pass the window sum, the multiply and the shared divider (speed quotient,
// then angular rate) before the next transaction is taken; other frames only the rate
// division. A zero span skips multiply and speed division, a zero track width the rate one.
// req_tready is high only while the sequencer waits for a frame.
// Reset is synchronous; history entries read as zero until written.
// A held result stalls only the final load of the output register.
module encoder_window_velocity_unit
   import ewv_pkg::*;
#(
   parameter int HISTORY_DEPTH = 10,
   parameter int SUM_SPAN      = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // frame_header, frame_command, tick_value, arrival_time_us
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // left_speed_q8, right_speed_q8, angular_rate_q8
   output logic [2:0]   rsp_tuser,   // left_updated, right_updated, zero_interval
   input  logic         csr_wr_en,
   input  logic [0:0]   csr_addr,
   input  logic [23:0]  csr_wdata
);

   localparam int N_SPAN    = (SUM_SPAN > HISTORY_DEPTH) ? HISTORY_DEPTH : SUM_SPAN;
   localparam int IDX_W     = $clog2(HISTORY_DEPTH);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int ENT_W     = TIME_W + BYTE_W;
   localparam int CNT_W     = $clog2(N_SPAN + 1);
   localparam int SUM_W     = BYTE_W + $clog2(N_SPAN);
   localparam int P1_W      = SUM_W + CIRC_W;
   localparam int LO_W      = P1_W / 2;
   localparam int MAG_W     = P1_W + MICROS_W;

   typedef enum logic [0:0] {
      CSR_WHEEL_CIRC  = 1'b0,
      CSR_TRACK_WIDTH = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM,
      S_MUL_A,
      S_MUL_LO,
      S_MUL_HI,
      S_SPD_GO,
      S_SPD_WAIT,
      S_RATE_GO,
      S_RATE_WAIT,
      S_OUT
   } state_type;

   state_type            state_ff;
   logic [CIRC_W-1:0]    circ_ff;
   logic [TRACK_W-1:0]   track_ff;
   logic [IDX_W-1:0]     slot_ff [2];
   logic [IDX_W-1:0]     ptr_ff;
   logic                 wheel_ff;
   logic [CNT_W-1:0]     issue_cnt_ff;
   logic [CNT_W-1:0]     recv_cnt_ff;
   logic                 rd_pend_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [TIME_W-1:0]    t_old_ff;
   logic [TIME_W-1:0]    span_ff;
   logic [P1_W-1:0]      prod1_ff;
   logic [MAG_W-1:0]     mag_ff;
   logic [SPEED_W-1:0]   left_speed_ff;
   logic [SPEED_W-1:0]   right_speed_ff;
   logic [SPEED_W-1:0]   rate_ff;
   logic                 rate_neg_ff;
   logic                 lu_ff, ru_ff, zi_ff;
   logic                 rsp_valid_ff;
   logic [119:0]         rsp_data_ff;
   logic [2:0]           rsp_user_ff;

   logic [ENT_W-1:0]     mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] vld_ff;
   logic [ENT_W-1:0]     rd_data_ff;
   logic                 rd_vld_ff;

   logic [BYTE_W-1:0]    in_hdr, in_cmd, in_tick;
   logic [TIME_W-1:0]    in_time;
   logic                 accept, is_left, is_right, is_wheel;
   logic                 rsp_load;
   logic [IDX_W-1:0]     cur_slot, slot_in, ptr_in;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr, rd_addr;
   logic signed [BYTE_W-1:0] ent_tick;
   logic [TIME_W-1:0]    ent_time, t_old_sel;
   logic [SUM_W-1:0]     sum_mag;
   logic signed [SPEED_W:0] diff;
   logic [SPEED_W:0]     diff_mag;
   logic [DIV_W-1:0]     spd_dividend, rate_dividend;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign in_hdr  = req_tdata[7:0];
   assign in_cmd  = req_tdata[15:8];
   assign in_tick = req_tdata[23:16];
   assign in_time = req_tdata[55:24];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_left    = (in_hdr == HDR_ENCODER) && (in_cmd == CMD_LEFT);
   assign is_right   = (in_hdr == HDR_ENCODER) && (in_cmd == CMD_RIGHT);
   assign is_wheel   = is_left || is_right;
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   assign cur_slot  = slot_ff[is_right];
   assign slot_in   = (cur_slot == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : cur_slot + IDX_W'(1);
   assign ptr_in    = (ptr_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + IDX_W'(1);
   assign mem_we    = accept && is_wheel;
   assign mem_waddr = {is_right, cur_slot};
   assign rd_addr   = {wheel_ff, ptr_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= {in_time, in_tick};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[mem_waddr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign ent_tick  = rd_vld_ff ? rd_data_ff[BYTE_W-1:0] : '0;
   assign ent_time  = rd_vld_ff ? rd_data_ff[ENT_W-1:BYTE_W] : '0;
   assign t_old_sel = (recv_cnt_ff == '0) ? ent_time : t_old_ff;

   assign sum_mag = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
   assign diff    = $signed({right_speed_ff[SPEED_W-1], right_speed_ff})
                  - $signed({left_speed_ff[SPEED_W-1], left_speed_ff});
   assign diff_mag = diff[SPEED_W] ? (~diff + (SPEED_W+1)'(1)) : diff;

   assign spd_dividend  = DIV_W'(mag_ff[MAG_W-1:TICK_SHIFT]);
   assign rate_dividend = DIV_W'({diff_mag, {TICK_SHIFT{1'b0}}});

   always_comb begin
      div_req.start    = (state_ff == S_SPD_GO) ||
                         ((state_ff == S_RATE_GO) && (track_ff != '0));
      div_req.dividend = (state_ff == S_SPD_GO) ? spd_dividend : rate_dividend;
      div_req.divisor  = (state_ff == S_SPD_GO) ? span_ff : DEN_W'(track_ff);
   end

   ewv_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         circ_ff        <= CIRC_RESET;
         track_ff       <= TRACK_RESET;
         slot_ff[0]     <= '0;
         slot_ff[1]     <= '0;
         ptr_ff         <= '0;
         wheel_ff       <= 1'b0;
         issue_cnt_ff   <= '0;
         recv_cnt_ff    <= '0;
         rd_pend_ff     <= 1'b0;
         sum_ff         <= '0;
         left_speed_ff  <= '0;
         right_speed_ff <= '0;
         lu_ff          <= 1'b0;
         ru_ff          <= 1'b0;
         zi_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_addr))
               CSR_WHEEL_CIRC:  circ_ff  <= csr_wdata[CIRC_W-1:0];
               CSR_TRACK_WIDTH: track_ff <= csr_wdata[TRACK_W-1:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         rd_pend_ff <= (state_ff == S_SUM) && (issue_cnt_ff < CNT_W'(N_SPAN));

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  lu_ff <= is_left;
                  ru_ff <= is_right;
                  zi_ff <= 1'b0;
                  if (is_wheel) begin
                     wheel_ff          <= is_right;
                     slot_ff[is_right] <= slot_in;
                     ptr_ff            <= slot_in;
                     issue_cnt_ff      <= '0;
                     recv_cnt_ff       <= '0;
                     sum_ff            <= '0;
                     state_ff          <= S_SUM;
                  end else begin
                     state_ff <= S_RATE_GO;
                  end
               end
            end
            S_SUM: begin
               if (issue_cnt_ff < CNT_W'(N_SPAN)) begin
                  ptr_ff       <= ptr_in;
                  issue_cnt_ff <= issue_cnt_ff + CNT_W'(1);
               end
               if (rd_pend_ff) begin
                  sum_ff      <= sum_ff + SUM_W'(ent_tick);
                  t_old_ff    <= t_old_sel;
                  recv_cnt_ff <= recv_cnt_ff + CNT_W'(1);
                  if (recv_cnt_ff == CNT_W'(N_SPAN - 1)) begin
                     span_ff  <= ent_time - t_old_sel;
                     state_ff <= S_MUL_A;
                  end
               end
            end
            S_MUL_A: begin
               if (span_ff == '0) begin
                  zi_ff <= 1'b1;
                  if (wheel_ff) begin
                     right_speed_ff <= '0;
                  end else begin
                     left_speed_ff <= '0;
                  end
                  state_ff <= S_RATE_GO;
               end else begin
                  prod1_ff <= P1_W'(sum_mag) * P1_W'(circ_ff);
                  state_ff <= S_MUL_LO;
               end
            end
            S_MUL_LO: begin
               mag_ff   <= MAG_W'(prod1_ff[LO_W-1:0]) * MAG_W'(MICROS_PER_SEC);
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               mag_ff   <= mag_ff + ((MAG_W'(prod1_ff[P1_W-1:LO_W]) * MAG_W'(MICROS_PER_SEC))
                                     << LO_W);
               state_ff <= S_SPD_GO;
            end
            S_SPD_GO: begin
               state_ff <= S_SPD_WAIT;
            end
            S_SPD_WAIT: begin
               if (div_rsp.done) begin
                  if (wheel_ff) begin
                     right_speed_ff <= sat_speed(sum_ff[SUM_W-1], div_rsp.quotient);
                  end else begin
                     left_speed_ff <= sat_speed(sum_ff[SUM_W-1], div_rsp.quotient);
                  end
                  state_ff <= S_RATE_GO;
               end
            end
            S_RATE_GO: begin
               rate_neg_ff <= diff[SPEED_W];
               if (track_ff == '0) begin
                  rate_ff  <= '0;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_RATE_WAIT;
               end
            end
            S_RATE_WAIT: begin
               if (div_rsp.done) begin
                  rate_ff  <= sat_speed(rate_neg_ff, div_rsp.quotient);
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_data_ff  <= {rate_ff, right_speed_ff, left_speed_ff};
                  rsp_user_ff  <= {zi_ff, ru_ff, lu_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> sv/ewv_checker.sv
// Port-level checks of the encoder window velocity unit and their binding.
module ewv_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready stayed high after an accepted transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp transaction changed");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]) &&
                     (!rsp_tuser[2] || rsp_tuser[0] || rsp_tuser[1]))
      else $error("inconsistent update flags");

   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |->
         (!rsp_tuser[0] || rsp_tdata[39:0] == 40'd0) &&
         (!rsp_tuser[1] || rsp_tdata[79:40] == 40'd0))
      else $error("zero interval with nonzero speed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not idle after reset");

endmodule

bind encoder_window_velocity_unit ewv_checker u_ewv_checker (.*);

>>> bench/encoder_window_velocity_unit_tb.sv
// Self-checking testbench for the encoder window velocity unit: directed table, then random frames.
`timescale 1ns / 1ps

module encoder_window_velocity_unit_tb
   import ewv_pkg::*;
;

   localparam int HISTORY_DEPTH = 10;
   localparam int SUM_SPAN      = 5;
   localparam int LEFT_WHEEL    = 0;
   localparam int RIGHT_WHEEL   = 1;

   localparam logic [0:0] REG_CIRCUMFERENCE = 1'b0;
   localparam logic [0:0] REG_TRACK_WIDTH   = 1'b1;

   localparam logic [2:0] FLAGS_NONE       = 3'b000;
   localparam logic [2:0] FLAGS_LEFT_ZERO  = 3'b101;
   localparam logic [2:0] FLAGS_RIGHT_ZERO = 3'b110;

   localparam int PHASES          = 6;
   localparam int FRAMES_PER_PHASE = 280;
   localparam int HOLD_AT_RESULT  = 700;
   localparam int HOLD_CYCLES     = 600;

   typedef struct packed {
      logic [SPEED_W-1:0] angular_rate;
      logic [SPEED_W-1:0] right_speed;
      logic [SPEED_W-1:0] left_speed;
      logic               zero_interval;
      logic               right_updated;
      logic               left_updated;
   } velocity_type;

   typedef struct packed {
      logic [7:0]  header;
      logic [7:0]  command;
      logic [7:0]  tick;
      logic [31:0] stamp;
      logic        typed;
      logic [2:0]  flags;
   } frame_row_type;

   localparam int DIRECTED_ROWS = 25;

   frame_row_type directed_frames [DIRECTED_ROWS] = '{
      '{8'h00, 8'h00, 8'h00, 32'h0000_0000, 1'b1, FLAGS_NONE},
      '{HDR_ENCODER, 8'h50, 8'h7F, 32'h0000_0001, 1'b1, FLAGS_NONE},
      '{8'hDC, CMD_LEFT, 8'h80, 32'h0000_0002, 1'b1, FLAGS_NONE},
      '{HDR_ENCODER, 8'h71, 8'h01, 32'h0000_0003, 1'b1, FLAGS_NONE},
      '{HDR_ENCODER, CMD_LEFT, 8'h7F, 32'd10, 1'b1, FLAGS_LEFT_ZERO},
      '{HDR_ENCODER, CMD_LEFT, 8'h80, 32'd20, 1'b1, FLAGS_LEFT_ZERO},
      '{HDR_ENCODER, CMD_LEFT, 8'h7F, 32'd30, 1'b1, FLAGS_LEFT_ZERO},
      '{HDR_ENCODER, CMD_LEFT, 8'h7F, 32'd40, 1'b1, FLAGS_LEFT_ZERO},
      '{HDR_ENCODER, CMD_LEFT, 8'h7F, 32'd50, 1'b1, FLAGS_LEFT_ZERO},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'hFFFF_FF00, 1'b1, FLAGS_RIGHT_ZERO},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'hFFFF_FF10, 1'b1, FLAGS_RIGHT_ZERO},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'hFFFF_FF20, 1'b1, FLAGS_RIGHT_ZERO},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'hFFFF_FF30, 1'b1, FLAGS_RIGHT_ZERO},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'hFFFF_FF40, 1'b1, FLAGS_RIGHT_ZERO},
      '{HDR_ENCODER, CMD_LEFT, 8'h7F, 32'd60, 1'b0, FLAGS_NONE},
      '{HDR_ENCODER, CMD_LEFT, 8'h7F, 32'd70, 1'b0, FLAGS_NONE},
      '{HDR_ENCODER, CMD_LEFT, 8'h7F, 32'd80, 1'b0, FLAGS_NONE},
      '{HDR_ENCODER, CMD_LEFT, 8'h80, 32'd90, 1'b0, FLAGS_NONE},
      '{HDR_ENCODER, CMD_LEFT, 8'h7F, 32'd100, 1'b0, FLAGS_NONE},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'hFFFF_FFF8, 1'b0, FLAGS_NONE},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'h0000_0004, 1'b0, FLAGS_NONE},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'h0000_0010, 1'b0, FLAGS_NONE},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'hFFFF_FFFF, 1'b0, FLAGS_NONE},
      '{HDR_ENCODER, CMD_RIGHT, 8'h80, 32'h0000_0020, 1'b0, FLAGS_NONE},
      '{8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, FLAGS_NONE}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [55:0]   req_tdata = '0;   // frame_header, frame_command, tick_value, arrival_time_us
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [119:0]  rsp_tdata;        // left_speed_q8, right_speed_q8, angular_rate_q8
   logic [2:0]    rsp_tuser;        // left_updated, right_updated, zero_interval
   logic          csr_wr_en = 1'b0;
   logic [0:0]    csr_addr = '0;
   logic [23:0]   csr_wdata = '0;

   logic signed [7:0]   tick_hist  [2][HISTORY_DEPTH];
   logic [31:0]         stamp_hist [2][HISTORY_DEPTH];
   int unsigned         hist_slot  [2];
   logic signed [SPEED_W-1:0] wheel_speed [2];
   logic [CIRC_W-1:0]   circ_q8  = CIRC_RESET;
   logic [TRACK_W-1:0]  track_q8 = TRACK_RESET;

   velocity_type pending_velocity [$];
   int        mismatches   = 0;
   int        results_seen = 0;
   bit        steady_sender = 1'b0;

   encoder_window_velocity_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [SPEED_W-1:0] clamp_q8(input logic neg, input logic [63:0] q);
      logic [63:0] lim;
      lim = 64'(1) << (SPEED_W - 1);
      if (neg) begin
         clamp_q8 = (q > lim) ? {1'b1, {(SPEED_W-1){1'b0}}} : SPEED_W'(64'(0) - q);
      end else begin
         clamp_q8 = (q > lim - 64'(1)) ? {1'b0, {(SPEED_W-1){1'b1}}} : q[SPEED_W-1:0];
      end
   endfunction

   // Returns 1 when the window spans zero time.
   function automatic logic push_wheel_sample(input int w, input logic signed [7:0] tick,
                                              input logic [31:0] stamp);
      int          span_n;
      int          sum;
      int unsigned s;
      logic [31:0] span;
      logic [63:0] mag;
      span_n = (SUM_SPAN > HISTORY_DEPTH) ? HISTORY_DEPTH : SUM_SPAN;
      tick_hist[w][hist_slot[w]]  = tick;
      stamp_hist[w][hist_slot[w]] = stamp;
      hist_slot[w] = (hist_slot[w] + 1) % HISTORY_DEPTH;
      s = hist_slot[w];
      sum = 0;
      for (int i = 0; i < span_n; i++) begin
         sum += tick_hist[w][(s + i) % HISTORY_DEPTH];
      end
      span = stamp_hist[w][(s + span_n - 1) % HISTORY_DEPTH] - stamp_hist[w][s];
      if (span == 32'd0) begin
         wheel_speed[w] = '0;
         return 1'b1;
      end
      mag = 64'(sum < 0 ? -sum : sum);
      mag = mag * 64'(circ_q8) * 64'(MICROS_PER_SEC);
      wheel_speed[w] = clamp_q8(sum < 0, mag / (64'(span) << TICK_SHIFT));
      return 1'b0;
   endfunction

   function automatic velocity_type predict_velocity(input logic [55:0] frame);
      velocity_type r;
      longint      diff;
      logic [63:0] mag;
      r = '0;
      if (frame[7:0] == HDR_ENCODER) begin
         if (frame[15:8] == CMD_LEFT) begin
            r.left_updated  = 1'b1;
            r.zero_interval = push_wheel_sample(LEFT_WHEEL, frame[23:16], frame[55:24]);
         end else if (frame[15:8] == CMD_RIGHT) begin
            r.right_updated = 1'b1;
            r.zero_interval = push_wheel_sample(RIGHT_WHEEL, frame[23:16], frame[55:24]);
         end
      end
      if (track_q8 != '0) begin
         diff = longint'(wheel_speed[RIGHT_WHEEL]) - longint'(wheel_speed[LEFT_WHEEL]);
         mag  = 64'(diff < 0 ? -diff : diff) << TICK_SHIFT;
         r.angular_rate = clamp_q8(diff < 0, mag / 64'(track_q8));
      end
      r.left_speed  = wheel_speed[LEFT_WHEEL];
      r.right_speed = wheel_speed[RIGHT_WHEEL];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [SPEED_W-1:0] want,
                              input logic [SPEED_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s expected %0d got %0d", $time, name,
                  $signed(want), $signed(got));
      end
   endtask

   task automatic send_frame(input logic [55:0] frame, input logic typed,
                             input logic [2:0] flags);
      int        gap;
      int        r;
      velocity_type want;
      r = $urandom_range(0, 99);
      if (steady_sender || r < 70) gap = 0;
      else if (r < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(20, 60);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= frame;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = predict_velocity(frame);
      if (typed) want = velocity_type'({120'd0, flags});
      pending_velocity.insert(pending_velocity.size(), want);
   endtask

   task automatic configure(input logic [CIRC_W-1:0] circ, input logic [TRACK_W-1:0] track);
      csr_wr_en <= 1'b1;
      csr_addr  <= REG_CIRCUMFERENCE;
      csr_wdata <= circ;
      @(posedge clock);
      circ_q8 = circ;
      csr_addr  <= REG_TRACK_WIDTH;
      csr_wdata <= 24'(track);
      @(posedge clock);
      track_q8 = track;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_velocity.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result side: check each transaction, stall at random, hold off once for a long stretch.
   initial begin
      velocity_type got;
      velocity_type want;
      int        stall_left;
      int        r;
      bit        held;
      stall_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = velocity_type'({rsp_tdata, rsp_tuser});
            if (pending_velocity.size() == 0) begin
               mismatches++;
               $display("%0t ns: unexpected transaction, expected none got %h",
                        $time, got);
            end else begin
               want = pending_velocity.pop_front();
               check_field("left_speed_q8", want.left_speed, got.left_speed);
               check_field("right_speed_q8", want.right_speed, got.right_speed);
               check_field("angular_rate_q8", want.angular_rate, got.angular_rate);
               check_field("left_updated", 40'(want.left_updated), 40'(got.left_updated));
               check_field("right_updated", 40'(want.right_updated), 40'(got.right_updated));
               check_field("zero_interval", 40'(want.zero_interval), 40'(got.zero_interval));
            end
            results_seen++;
         end
         if (stall_left != 0) begin
            stall_left--;
         end else if (!held && results_seen >= HOLD_AT_RESULT) begin
            held = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if ((results_seen / 128) % 4 != 0) begin
            r = $urandom_range(0, 99);
            if (r < 10) stall_left = $urandom_range(1, 3);
            else if (r < 13) stall_left = $urandom_range(20, 60);
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   initial begin
      logic [31:0] wheel_clock [2];
      logic [7:0]  header;
      logic [7:0]  command;
      logic [7:0]  tick;
      logic [31:0] stamp;
      logic [CIRC_W-1:0]  circ;
      logic [TRACK_W-1:0] track;
      int          encoder_sent;
      int          wheel;
      int          r;

      for (int w = 0; w < 2; w++) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            tick_hist[w][i]  = '0;
            stamp_hist[w][i] = '0;
         end
         hist_slot[w]   = 0;
         wheel_speed[w] = '0;
         wheel_clock[w] = $urandom;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_frames[i]) begin
         send_frame({directed_frames[i].stamp, directed_frames[i].tick,
                     directed_frames[i].command, directed_frames[i].header},
                    directed_frames[i].typed, directed_frames[i].flags);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: begin circ = 24'hFF_FFFF; track = 16'd1; end
            1: begin circ = 24'd0; track = 16'hFFFF; end
            2: begin circ = 24'($urandom); track = 16'd0; end
            3: begin circ = 24'd1; track = 16'($urandom_range(1, 65535)); end
            4: begin circ = 24'($urandom); track = 16'($urandom_range(1, 65535)); end
            default: begin circ = CIRC_RESET; track = TRACK_RESET; end
         endcase
         configure(circ, track);
         steady_sender = ($urandom_range(0, 3) == 0);
         encoder_sent = 0;
         while (encoder_sent < FRAMES_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               header = $urandom_range(0, 1) ? 8'($urandom) : HDR_ENCODER;
               case ($urandom_range(0, 2))
                  0: command = CMD_LEFT;
                  1: command = CMD_RIGHT;
                  default: command = 8'($urandom);
               endcase
               tick  = 8'($urandom);
               stamp = $urandom;
            end else begin
               wheel   = (r < 54) ? LEFT_WHEEL : RIGHT_WHEEL;
               header  = HDR_ENCODER;
               command = (wheel == LEFT_WHEEL) ? CMD_LEFT : CMD_RIGHT;
               if ($urandom_range(0, 9) < 2) tick = $urandom_range(0, 1) ? 8'h7F : 8'h80;
               else tick = 8'($urandom);
               r = $urandom_range(0, 99);
               if (r < 30) stamp = 32'd0;
               else if (r < 60) stamp = $urandom_range(1, 3);
               else if (r < 85) stamp = $urandom_range(1, 1000);
               else if (r < 95) stamp = $urandom_range(1, 1 << 20);
               else stamp = $urandom;
               wheel_clock[wheel] = wheel_clock[wheel] + stamp;
               stamp = wheel_clock[wheel];
               encoder_sent++;
            end
            send_frame({stamp, tick, command, header}, 1'b0, FLAGS_NONE);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_velocity.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
